// ===== src/sscs_pkg.sv =====
package sscs_pkg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PULSE = 2'd1,
        OP_SPEED = 2'd2
    } op_t;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_CLOSE_HOLD     = 3'd0,
        PH_PICK_SETTLE    = 3'd1,
        PH_PICK_MOVE      = 3'd2,
        PH_OPEN_HOLD      = 3'd3,
        PH_XFER_SETTLE    = 3'd4,
        PH_XFER_MOVE      = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ONE  = 2'd0,
        KIND_CONV = 2'd1,
        KIND_TWO  = 2'd2
    } kind_t;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_PICKUP   = 3'd0,
        REG_DIG      = 3'd1,
        REG_LEAD     = 3'd2,
        REG_CONVEYOR = 3'd3,
        REG_HOLD     = 3'd4,
        REG_SETTLE   = 3'd5
    } reg_idx_t;

    localparam int ADDR_W = 5;
    localparam int NUM_MOTORS = 4;

    localparam int MOT_PICK = 0;
    localparam int MOT_DIG  = 1;
    localparam int MOT_LEAD = 2;
    localparam int MOT_CONV = 3;

    localparam logic [10:0] SERVO_CLOSED   = 11'd630;
    localparam logic [10:0] SERVO_RELEASED = 11'd210;
    localparam logic [10:0] START_COMPARE  = 11'd100;

    localparam logic [7:0]  CHAR_A = 8'h41;
    localparam logic [7:0]  CHAR_B = 8'h42;
    localparam logic [7:0]  CHAR_C = 8'h43;

    localparam logic [11:0] PERIOD_A  = 12'd2399;
    localparam logic [11:0] PERIOD_B  = 12'd199;
    localparam logic [11:0] PERIOD_C  = 12'd1199;
    localparam logic [10:0] COMPARE_A = 11'd1200;
    localparam logic [10:0] COMPARE_B = 11'd100;
    localparam logic [10:0] COMPARE_C = 11'd600;

    localparam logic [15:0] RST_PICKUP_STEPS   = 16'd400;
    localparam logic [15:0] RST_DIG_STEPS      = 16'd1000;
    localparam logic [15:0] RST_LEAD_STEPS     = 16'd3200;
    localparam logic [15:0] RST_CONVEYOR_STEPS = 16'd300;
    localparam logic [15:0] RST_HOLD_TICKS     = 16'd500;
    localparam logic [7:0]  RST_SETTLE_TICKS   = 8'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] pulse_mask;
        logic [7:0] command_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [11:0] step_period;
        logic [10:0] pickup_compare;
        logic [10:0] dig_compare;
        logic [10:0] lead_compare;
        logic [10:0] conveyor_compare;
        logic [3:0]  direction_bits;
        logic [10:0] servo_pulse;
        logic [2:0]  indicator_bits;
        logic [3:0]  cycle_position;
        logic        counter_restart;
    } out_item_t;

endpackage

// ===== src/servo_stepper_cycle_sequencer_core.sv =====
// Servo gripper and stepper cycle sequencer.
//
// Input channel (s_valid/s_ready/s_item): one item per event - a millisecond
// tick, a set of finished step pulses, or a speed command byte. Every item
// produces exactly one result item on the output channel (m_valid/m_ready/
// m_item) showing the sequencer state after that event.
//
// Flow: an item accepted at a clock edge is captured in the input register,
// worked through one level of compare/increment logic, and registered into the
// result register (raising m_valid) once that is empty or being drained.
// Throughput is one item per cycle while the output is not stalled; the state
// update of one item is finished before the next item leaves the input register.
//
// Stall: while m_valid is high and m_ready low, the result register holds and
// the input register fills; s_ready drops only once both are occupied.
//
// Reset (aresetn low at a clock edge): both channels empty, servo closed,
// close-hold phase, all motors idle, step period 199, registers at defaults.
// Configuration (APB, pready always high) is to be written by the user only while idle; the block does not enforce it.
module servo_stepper_cycle_sequencer_core #(
    parameter int PLANTS_PER_HALF = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sscs_pkg::in_item_t            s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sscs_pkg::out_item_t           m_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sscs_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import sscs_pkg::*;

    // Position counter must hold 2*PLANTS_PER_HALF and still show 4 bits
    localparam int PosBits = $clog2(2 * PLANTS_PER_HALF + 1);
    localparam int PosW    = (PosBits > 4) ? PosBits : 4;
    localparam logic [PosW-1:0] PosHalf = PosW'(PLANTS_PER_HALF);
    localparam logic [PosW-1:0] PosWrap = PosW'(2 * PLANTS_PER_HALF);

    // Configuration registers
    logic [15:0] pickup_steps_reg;
    logic [15:0] dig_steps_reg;
    logic [15:0] lead_steps_reg;
    logic [15:0] conveyor_steps_reg;
    logic [15:0] hold_ticks_reg;
    logic [7:0]  settle_ticks_reg;

    // Pipeline registers
    logic      in_valid_reg;
    in_item_t  in_reg;
    logic      out_valid_reg;
    out_item_t out_reg;
    logic      advance;

    // Sequencer state
    phase_t          phase_reg, phase_next;
    kind_t           kind_reg, kind_next;
    logic [15:0]     delay_reg, delay_next;
    logic [PosW-1:0] pos_reg, pos_next;
    logic [15:0]     done_reg   [NUM_MOTORS];
    logic [15:0]     done_next  [NUM_MOTORS];
    logic [15:0]     target_reg [NUM_MOTORS];
    logic [15:0]     target_next[NUM_MOTORS];
    logic [10:0]     cmp_reg    [NUM_MOTORS];
    logic [10:0]     cmp_next   [NUM_MOTORS];
    logic [11:0]     period_reg, period_next;
    logic [3:0]      dir_reg, dir_next;
    logic [2:0]      ind_reg, ind_next;
    logic [10:0]     servo_reg, servo_next;

    // Shared event decode
    logic            is_tick;
    logic            is_pulse;
    logic            is_speed;
    logic [15:0]     hold_limit;
    logic [15:0]     delay_inc;
    logic            hold_hit;
    logic            pick_idle;
    logic            xfer_idle;
    logic [PosW-1:0] pos_inc;
    kind_t           kind_new;
    logic [3:0]      start_mask;
    logic [15:0]     motor_steps[NUM_MOTORS];
    logic            speed_hit;
    logic [11:0]     speed_period;
    logic [10:0]     speed_cmp;
    out_item_t       result;

    // ---------------------------------------------------------------------
    // Handshake: advance the input register into the result register
    // whenever the result register is empty or being drained.
    // ---------------------------------------------------------------------
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pickup_steps_reg   <= RST_PICKUP_STEPS;
            dig_steps_reg      <= RST_DIG_STEPS;
            lead_steps_reg     <= RST_LEAD_STEPS;
            conveyor_steps_reg <= RST_CONVEYOR_STEPS;
            hold_ticks_reg     <= RST_HOLD_TICKS;
            settle_ticks_reg   <= RST_SETTLE_TICKS;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx_t'(paddr[4:2]))
                REG_PICKUP:   pickup_steps_reg   <= pwdata[15:0];
                REG_DIG:      dig_steps_reg      <= pwdata[15:0];
                REG_LEAD:     lead_steps_reg     <= pwdata[15:0];
                REG_CONVEYOR: conveyor_steps_reg <= pwdata[15:0];
                REG_HOLD:     hold_ticks_reg     <= pwdata[15:0];
                REG_SETTLE:   settle_ticks_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_PICKUP:   prdata = {16'd0, pickup_steps_reg};
            REG_DIG:      prdata = {16'd0, dig_steps_reg};
            REG_LEAD:     prdata = {16'd0, lead_steps_reg};
            REG_CONVEYOR: prdata = {16'd0, conveyor_steps_reg};
            REG_HOLD:     prdata = {16'd0, hold_ticks_reg};
            REG_SETTLE:   prdata = {24'd0, settle_ticks_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Event decode and shared compares
    // ---------------------------------------------------------------------
    assign is_tick  = in_reg.operation == OP_TICK;
    assign is_pulse = in_reg.operation == OP_PULSE;
    assign is_speed = in_reg.operation == OP_SPEED;

    // Hold phases count against the servo hold, settle phases against settle;
    // a limit of zero ends the phase on the first tick as well.
    assign hold_limit = (phase_reg == PH_CLOSE_HOLD || phase_reg == PH_OPEN_HOLD)
                        ? hold_ticks_reg : {8'd0, settle_ticks_reg};
    assign delay_inc  = delay_reg + 16'd1;
    assign hold_hit   = delay_inc >= hold_limit;

    assign pick_idle = (target_reg[MOT_PICK] == 16'd0) && (target_reg[MOT_DIG] == 16'd0);
    assign xfer_idle = pick_idle && ((kind_reg == KIND_CONV) ? target_reg[MOT_CONV] == 16'd0
                                                             : target_reg[MOT_LEAD] == 16'd0);

    // Next transfer kind, picked when the open hold ends
    assign pos_inc = pos_reg + PosW'(1);

    always_comb begin
        if (pos_inc == PosHalf || pos_inc == PosWrap) begin
            kind_new = KIND_CONV;
        end else if (pos_inc < PosHalf) begin
            kind_new = KIND_ONE;
        end else begin
            kind_new = KIND_TWO;
        end
    end

    assign motor_steps[MOT_PICK] = pickup_steps_reg;
    assign motor_steps[MOT_DIG]  = dig_steps_reg;
    assign motor_steps[MOT_LEAD] = lead_steps_reg;
    assign motor_steps[MOT_CONV] = conveyor_steps_reg;

    always_comb begin
        speed_hit    = 1'b1;
        speed_period = PERIOD_B;
        speed_cmp    = COMPARE_B;
        case (in_reg.command_byte)
            CHAR_A: begin
                speed_period = PERIOD_A;
                speed_cmp    = COMPARE_A;
            end
            CHAR_B: begin
                speed_period = PERIOD_B;
                speed_cmp    = COMPARE_B;
            end
            CHAR_C: begin
                speed_period = PERIOD_C;
                speed_cmp    = COMPARE_C;
            end
            default: speed_hit = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Phase sequencing: next state
    // ---------------------------------------------------------------------
    always_comb begin
        phase_next = phase_reg;
        if (is_tick) begin
            unique case (phase_reg)
                PH_CLOSE_HOLD:  if (hold_hit)  phase_next = PH_PICK_SETTLE;
                PH_PICK_SETTLE: if (hold_hit)  phase_next = PH_PICK_MOVE;
                PH_PICK_MOVE:   if (pick_idle) phase_next = PH_OPEN_HOLD;
                PH_OPEN_HOLD:   if (hold_hit)  phase_next = PH_XFER_SETTLE;
                PH_XFER_SETTLE: if (hold_hit)  phase_next = PH_XFER_MOVE;
                PH_XFER_MOVE:   if (xfer_idle) phase_next = PH_CLOSE_HOLD;
                default:                       phase_next = PH_CLOSE_HOLD;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Phase sequencing: datapath updates on ticks
    // ---------------------------------------------------------------------
    always_comb begin
        kind_next  = kind_reg;
        delay_next = delay_reg;
        pos_next   = pos_reg;
        dir_next   = dir_reg;
        ind_next   = ind_reg;
        servo_next = servo_reg;
        start_mask = 4'd0;
        if (is_tick) begin
            unique case (phase_reg) inside
                PH_CLOSE_HOLD, PH_PICK_SETTLE, PH_OPEN_HOLD, PH_XFER_SETTLE: begin
                    delay_next = hold_hit ? 16'd0 : delay_inc;
                end
                default: ;
            endcase
            unique case (phase_reg)
                PH_CLOSE_HOLD: begin
                    if (hold_hit) begin
                        dir_next[MOT_PICK] = 1'b1;
                        dir_next[MOT_DIG]  = 1'b0;
                    end
                end
                PH_PICK_SETTLE: begin
                    if (hold_hit) begin
                        start_mask[MOT_PICK] = 1'b1;
                        start_mask[MOT_DIG]  = 1'b1;
                    end
                end
                PH_PICK_MOVE: begin
                    if (pick_idle) begin
                        servo_next = SERVO_RELEASED;
                        delay_next = 16'd0;
                    end
                end
                PH_OPEN_HOLD: begin
                    if (hold_hit) begin
                        kind_next = kind_new;
                        pos_next  = (pos_inc >= PosWrap) ? '0 : pos_inc;
                        case (kind_new)
                            KIND_ONE: begin
                                ind_next           = 3'b001;
                                dir_next[MOT_PICK] = 1'b0;
                                dir_next[MOT_DIG]  = 1'b1;
                                dir_next[MOT_LEAD] = 1'b1;
                            end
                            KIND_CONV: begin
                                ind_next           = 3'b010;
                                dir_next[MOT_PICK] = 1'b1;
                                dir_next[MOT_DIG]  = 1'b0;
                                dir_next[MOT_CONV] = 1'b0;
                            end
                            default: begin
                                ind_next           = 3'b100;
                                dir_next[MOT_PICK] = 1'b0;
                                dir_next[MOT_DIG]  = 1'b1;
                                dir_next[MOT_LEAD] = 1'b0;
                            end
                        endcase
                    end
                end
                PH_XFER_SETTLE: begin
                    if (hold_hit) begin
                        start_mask[MOT_PICK] = 1'b1;
                        start_mask[MOT_DIG]  = 1'b1;
                        if (kind_reg == KIND_CONV) begin
                            start_mask[MOT_CONV] = 1'b1;
                        end else begin
                            start_mask[MOT_LEAD] = 1'b1;
                        end
                    end
                end
                PH_XFER_MOVE: begin
                    if (xfer_idle) begin
                        servo_next = SERVO_CLOSED;
                        delay_next = 16'd0;
                    end
                end
                default: begin
                    servo_next = SERVO_CLOSED;
                    delay_next = 16'd0;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Per-motor step counting, starts and speed commands
    // ---------------------------------------------------------------------
    always_comb begin
        logic [15:0] step_inc;
        period_next = period_reg;
        if (is_speed && speed_hit) begin
            period_next = speed_period;
        end
        for (int k = 0; k < NUM_MOTORS; k++) begin
            done_next[k]   = done_reg[k];
            target_next[k] = target_reg[k];
            cmp_next[k]    = cmp_reg[k];
            step_inc       = done_reg[k] + 16'd1;
            // Start: load the target only on an idle motor
            if (start_mask[k]) begin
                cmp_next[k] = START_COMPARE;
                if (target_reg[k] == 16'd0) begin
                    target_next[k] = motor_steps[k];
                    done_next[k]   = 16'd0;
                end
            end
            // Count a finished pulse; drop the compare at the target
            if (is_pulse && in_reg.pulse_mask[k] && target_reg[k] != 16'd0) begin
                done_next[k] = step_inc;
                if (step_inc >= target_reg[k]) begin
                    cmp_next[k]    = 11'd0;
                    target_next[k] = 16'd0;
                end
            end
            if (is_speed && speed_hit) begin
                cmp_next[k] = speed_cmp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_CLOSE_HOLD;
            kind_reg   <= KIND_ONE;
            delay_reg  <= 16'd0;
            pos_reg    <= '0;
            period_reg <= PERIOD_B;
            dir_reg    <= 4'd0;
            ind_reg    <= 3'd0;
            servo_reg  <= SERVO_CLOSED;
            for (int k = 0; k < NUM_MOTORS; k++) begin
                done_reg[k]   <= 16'd0;
                target_reg[k] <= 16'd0;
                cmp_reg[k]    <= 11'd0;
            end
        end else if (advance) begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            delay_reg  <= delay_next;
            pos_reg    <= pos_next;
            period_reg <= period_next;
            dir_reg    <= dir_next;
            ind_reg    <= ind_next;
            servo_reg  <= servo_next;
            for (int k = 0; k < NUM_MOTORS; k++) begin
                done_reg[k]   <= done_next[k];
                target_reg[k] <= target_next[k];
                cmp_reg[k]    <= cmp_next[k];
            end
        end
    end

    // Result shows the state after this item
    always_comb begin
        result.phase            = phase_next;
        result.step_period      = period_next;
        result.pickup_compare   = cmp_next[MOT_PICK];
        result.dig_compare      = cmp_next[MOT_DIG];
        result.lead_compare     = cmp_next[MOT_LEAD];
        result.conveyor_compare = cmp_next[MOT_CONV];
        result.direction_bits   = dir_next;
        result.servo_pulse      = servo_next;
        result.indicator_bits   = ind_next;
        result.cycle_position   = pos_next[3:0];
        result.counter_restart  = is_speed;
    end

endmodule

// ===== src/sscs_checker.sv =====
module sscs_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  sscs_pkg::out_item_t           m_item
);
    import sscs_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.phase <= 3'd5)
        else $error("phase out of range");

    a_servo_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.servo_pulse == SERVO_CLOSED
                    || m_item.servo_pulse == SERVO_RELEASED)
        else $error("servo pulse neither open nor closed");

    a_indicator: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0(m_item.indicator_bits))
        else $error("more than one transfer indicator set");

    a_period: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.step_period == PERIOD_A || m_item.step_period == PERIOD_B
                    || m_item.step_period == PERIOD_C)
        else $error("step period not a known speed");

endmodule

bind servo_stepper_cycle_sequencer_core sscs_checker u_sscs_checker (.*);
